// File: hdl/hook_arm_motion_sequencer_core_defines.svh
// ----------------------------------------------------------------------------
// hook arm motion sequencer assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef HOOK_ARM_MOTION_SEQUENCER_CORE_DEFINES_SVH
`define HOOK_ARM_MOTION_SEQUENCER_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define HAMS_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("hams check failed");

// next-cycle implication, disabled in reset
`define HAMS_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("hams check failed");

`endif

// File: hdl/hams_pkg.sv
// ----------------------------------------------------------------------------
// hams_pkg
// types and codes shared by the hook arm motion sequencer
// ----------------------------------------------------------------------------
package hams_pkg;

  localparam int DIST_W   = 23;
  localparam int DWELL_W  = 16;
  localparam int STEP_W   = 4;
  localparam int OP_W     = 3;
  localparam int DRIVE_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 23;

  // opcodes
  localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
  localparam logic [OP_W-1:0] OP_GRAB    = 3'd1;
  localparam logic [OP_W-1:0] OP_RELEASE = 3'd2;
  localparam logic [OP_W-1:0] OP_SAFETY  = 3'd3;
  localparam logic [OP_W-1:0] OP_LEAN    = 3'd4;
  localparam logic [OP_W-1:0] OP_STOP    = 3'd5;
  localparam logic [OP_W-1:0] OP_PUSH    = 3'd6;
  localparam logic [OP_W-1:0] OP_PULL    = 3'd7;

  // sequence steps
  localparam logic [STEP_W-1:0] ST_IDLE      = 4'd0;
  localparam logic [STEP_W-1:0] ST_G_PUSH    = 4'd1;
  localparam logic [STEP_W-1:0] ST_G_WAIT    = 4'd2;
  localparam logic [STEP_W-1:0] ST_G_DWELL   = 4'd3;
  localparam logic [STEP_W-1:0] ST_G_RETRACT = 4'd4;
  localparam logic [STEP_W-1:0] ST_R_PUSH    = 4'd5;
  localparam logic [STEP_W-1:0] ST_R_WAIT    = 4'd6;
  localparam logic [STEP_W-1:0] ST_R_DWELL   = 4'd7;
  localparam logic [STEP_W-1:0] ST_R_RETRACT = 4'd8;
  localparam logic [STEP_W-1:0] ST_S_PUSH    = 4'd9;
  localparam logic [STEP_W-1:0] ST_S_WAIT    = 4'd10;
  localparam logic [STEP_W-1:0] ST_L_START   = 4'd11;
  localparam logic [STEP_W-1:0] ST_L_RETRACT = 4'd12;

  // motor drive codes
  localparam logic [DRIVE_W-1:0] DRV_STOP = 2'b00;
  localparam logic [DRIVE_W-1:0] DRV_FWD  = 2'b01;
  localparam logic [DRIVE_W-1:0] DRV_BACK = 2'b11;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OUT_DISTANCE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RETRACT_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DWELL_TICKS   = 2'd2;

  // register reset values
  localparam logic [DIST_W-1:0]  OUT_DISTANCE_RST  = 23'd22500;
  localparam logic [DIST_W-1:0]  RETRACT_LIMIT_RST = 23'd18;
  localparam logic [DWELL_W-1:0] DWELL_TICKS_RST   = 16'd25;

  typedef struct packed {
    logic [DIST_W-1:0]  out_distance;
    logic [DIST_W-1:0]  retract_limit;
    logic [DWELL_W-1:0] dwell_ticks;
  } cfg_t;

  typedef struct packed {
    logic [STEP_W-1:0]  step;
    logic [DIST_W-1:0]  target;
    logic [DWELL_W-1:0] dwell;
    logic [DRIVE_W-1:0] drive;
    logic               hook;
  } seq_state_t;

  typedef struct packed {
    logic [DRIVE_W-1:0] drive;
    logic               hook;
    logic               pulse;
    logic [STEP_W-1:0]  step;
    logic               moving;
  } result_t;

endpackage

// File: hdl/hams_channels.sv
// ----------------------------------------------------------------------------
// hams channels
// valid/ready channel interfaces for command, result and register write words
// ----------------------------------------------------------------------------

// command and sensor word
interface hams_in_if #(
  parameter int POSITION_BITS = 24
);
  logic                            valid;
  logic                            ready;
  logic [2:0]                      opcode;
  logic [22:0]                     target_distance;
  logic signed [POSITION_BITS-1:0] rail_position;
  logic                            home_pressed;

  modport source (output valid, opcode, target_distance, rail_position, home_pressed,
                  input ready);
  modport sink   (input valid, opcode, target_distance, rail_position, home_pressed,
                  output ready);
endinterface

// actuator result word
interface hams_out_if;
  logic              valid;
  logic              ready;
  logic signed [1:0] motor_drive;
  logic              hook_engaged;
  logic              encoder_reset;
  logic [3:0]        sequence_step;
  logic              override_moving;

  modport source (output valid, motor_drive, hook_engaged, encoder_reset, sequence_step,
                  override_moving, input ready);
  modport sink   (input valid, motor_drive, hook_engaged, encoder_reset, sequence_step,
                  override_moving, output ready);
endinterface

// register write word
interface hams_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [22:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/hams_cfg_regs.sv
// ----------------------------------------------------------------------------
// hams_cfg_regs
// register bank for distance, retract limit and dwell settings
// ----------------------------------------------------------------------------
module hams_cfg_regs (
  input  logic           clk,
  input  logic           rst_n,
  hams_cfg_if.sink       cfg_if,
  output hams_pkg::cfg_t cfg
);
  import hams_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_if.ready = 1'b1;
  assign cfg = cfg_r;

  // decode the write index; unlisted indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_OUT_DISTANCE:  cfg_nxt.out_distance  = cfg_if.data;
        REG_RETRACT_LIMIT: cfg_nxt.retract_limit = cfg_if.data;
        REG_DWELL_TICKS:   cfg_nxt.dwell_ticks   = cfg_if.data[DWELL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.out_distance  <= OUT_DISTANCE_RST;
      cfg_r.retract_limit <= RETRACT_LIMIT_RST;
      cfg_r.dwell_ticks   <= DWELL_TICKS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: hdl/hams_step_logic.sv
// ----------------------------------------------------------------------------
// hams_step_logic
// one sequencer transition: next state and result word for one command
// ----------------------------------------------------------------------------
module hams_step_logic #(
  parameter int POSITION_BITS = 24
) (
  input  logic [2:0]                      opcode,
  input  logic [22:0]                     target_distance,
  input  logic signed [POSITION_BITS-1:0] rail_position,
  input  logic                            home_pressed,
  input  hams_pkg::cfg_t                  cfg,
  input  hams_pkg::seq_state_t            st,
  output hams_pkg::seq_state_t            st_nxt,
  output hams_pkg::result_t               res
);
  import hams_pkg::*;

  // compare width holds the position and any unsigned 23-bit threshold
  localparam int CMP_W = (POSITION_BITS > DIST_W + 1) ? POSITION_BITS : DIST_W + 1;

  logic signed [CMP_W-1:0] pos_ext;
  logic signed [CMP_W-1:0] out_ext;
  logic signed [CMP_W-1:0] tgt_ext;
  logic signed [CMP_W-1:0] lim_ext;
  logic                    reach_out;
  logic                    reach_tgt;
  logic                    below_tgt;
  logic                    below_lim;
  logic [DWELL_W-1:0]      dwell_inc;
  logic                    dwell_done;
  logic                    pulse;
  logic                    moving;

  // threshold compares
  always_comb begin
    pos_ext   = CMP_W'(rail_position);
    out_ext   = $signed(CMP_W'(cfg.out_distance));
    tgt_ext   = $signed(CMP_W'(st.target));
    lim_ext   = $signed(CMP_W'(cfg.retract_limit));
    reach_out = pos_ext >= out_ext;
    reach_tgt = pos_ext >= tgt_ext;
    below_tgt = pos_ext <= tgt_ext;
    below_lim = pos_ext <= lim_ext;
  end

  // saturating dwell counter
  always_comb begin
    dwell_inc  = (st.dwell != {DWELL_W{1'b1}}) ? st.dwell + 1'b1 : st.dwell;
    dwell_done = dwell_inc >= cfg.dwell_ticks;
  end

  // command decode and step advance
  always_comb begin
    st_nxt = st;
    pulse  = 1'b0;
    moving = 1'b0;
    unique case (opcode) inside
      OP_TICK: begin
        unique case (st.step)
          ST_G_PUSH: begin
            st_nxt.hook  = 1'b0;
            st_nxt.drive = DRV_FWD;
            st_nxt.step  = ST_G_WAIT;
          end
          ST_G_WAIT: begin
            if (reach_out) begin
              st_nxt.drive = DRV_STOP;
              st_nxt.hook  = 1'b1;
              st_nxt.dwell = '0;
              st_nxt.step  = ST_G_DWELL;
            end
          end
          ST_G_DWELL, ST_R_DWELL: begin
            st_nxt.dwell = dwell_inc;
            if (dwell_done) begin
              st_nxt.drive = DRV_BACK;
              st_nxt.step  = (st.step == ST_G_DWELL) ? ST_G_RETRACT : ST_R_RETRACT;
            end
          end
          ST_G_RETRACT, ST_L_RETRACT: begin
            if (below_tgt || home_pressed) begin
              pulse        = home_pressed;
              st_nxt.drive = DRV_STOP;
              st_nxt.step  = ST_IDLE;
            end
          end
          ST_R_PUSH: begin
            st_nxt.drive = DRV_FWD;
            st_nxt.step  = ST_R_WAIT;
          end
          ST_R_WAIT: begin
            // motor keeps driving forward into the dwell
            if (reach_out) begin
              st_nxt.hook  = 1'b0;
              st_nxt.dwell = '0;
              st_nxt.step  = ST_R_DWELL;
            end
          end
          ST_R_RETRACT: begin
            if (below_lim || home_pressed) begin
              pulse        = home_pressed;
              st_nxt.drive = DRV_STOP;
              st_nxt.step  = ST_IDLE;
            end
          end
          ST_S_PUSH: begin
            st_nxt.drive = DRV_FWD;
            st_nxt.step  = ST_S_WAIT;
          end
          ST_S_WAIT: begin
            if (reach_tgt) begin
              st_nxt.drive = DRV_STOP;
              st_nxt.hook  = 1'b1;
              st_nxt.step  = ST_IDLE;
            end
          end
          ST_L_START: begin
            st_nxt.drive = DRV_BACK;
            st_nxt.hook  = 1'b1;
            st_nxt.step  = ST_L_RETRACT;
          end
          default: ;
        endcase
      end
      OP_GRAB, OP_SAFETY, OP_LEAN: begin
        // starts are honored from idle only
        if (st.step == ST_IDLE) begin
          st_nxt.target = target_distance;
          st_nxt.step   = (opcode == OP_GRAB)   ? ST_G_PUSH :
                          (opcode == OP_SAFETY) ? ST_S_PUSH : ST_L_START;
        end
      end
      OP_RELEASE: begin
        if (st.step == ST_IDLE) begin
          st_nxt.step = ST_R_PUSH;
        end
      end
      OP_STOP: begin
        st_nxt.drive = DRV_STOP;
        st_nxt.step  = ST_IDLE;
      end
      OP_PUSH: begin
        st_nxt.drive = DRV_FWD;
        st_nxt.step  = ST_IDLE;
      end
      default: begin
        // pull override
        st_nxt.step = ST_IDLE;
        if (!home_pressed) begin
          st_nxt.drive = DRV_BACK;
          moving       = 1'b1;
        end else begin
          st_nxt.drive = DRV_STOP;
          pulse        = 1'b1;
        end
      end
    endcase
  end

  // result word reflects the state after the transition
  always_comb begin
    res.drive  = st_nxt.drive;
    res.hook   = st_nxt.hook;
    res.pulse  = pulse;
    res.step   = st_nxt.step;
    res.moving = moving;
  end

endmodule

// File: hdl/hook_arm_motion_sequencer_core.sv
// ----------------------------------------------------------------------------
// hook_arm_motion_sequencer_core
// grab, release, safety and lean-in sequencer for a lead-screw hook arm
// ----------------------------------------------------------------------------
// The block takes one command or tick word per clock while results are taken,
// and returns exactly one result word for each: the word is captured in
// an input register, one step transition (a single position or dwell compare
// and a step decode) runs between that register and the result register, and
// the sequencer state updates in the same cycle. A waiting result lets the
// next word enter only an empty input register. Register writes take effect
// on the cycle after the write and need no warm-up after reset.
module hook_arm_motion_sequencer_core #(
  parameter int POSITION_BITS = 24
) (
  input  logic      clk,
  input  logic      rst_n,
  hams_in_if.sink   in_if,
  hams_out_if.source out_if,
  hams_cfg_if.sink  cfg_if
);
  import hams_pkg::*;

  cfg_t       cfg;
  seq_state_t st_r;
  seq_state_t st_nxt;
  result_t    res;
  result_t    res_r;

  logic                            s1_valid_r;
  logic [OP_W-1:0]                 s1_opcode_r;
  logic [DIST_W-1:0]               s1_target_r;
  logic signed [POSITION_BITS-1:0] s1_pos_r;
  logic                            s1_home_r;
  logic                            out_valid_r;
  logic                            s1_adv;

  hams_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  hams_step_logic #(
    .POSITION_BITS (POSITION_BITS)
  ) u_step (
    .opcode          (s1_opcode_r),
    .target_distance (s1_target_r),
    .rail_position   (s1_pos_r),
    .home_pressed    (s1_home_r),
    .cfg             (cfg),
    .st              (st_r),
    .st_nxt          (st_nxt),
    .res             (res)
  );

  // handshake: the input register empties whenever the result register can load
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || s1_adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      s1_opcode_r <= in_if.opcode;
      s1_target_r <= in_if.target_distance;
      s1_pos_r    <= in_if.rail_position;
      s1_home_r   <= in_if.home_pressed;
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (s1_adv) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_r <= res;
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.motor_drive     = $signed(res_r.drive);
  assign out_if.hook_engaged    = res_r.hook;
  assign out_if.encoder_reset   = res_r.pulse;
  assign out_if.sequence_step   = res_r.step;
  assign out_if.override_moving = res_r.moving;

endmodule

// File: hdl/hams_checker.sv
// ----------------------------------------------------------------------------
// hams_checker
// port-level checks on the sequencer result channel
// ----------------------------------------------------------------------------
`include "hook_arm_motion_sequencer_core_defines.svh"

module hams_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [1:0] motor_drive,
  input logic              encoder_reset,
  input logic [3:0]        sequence_step,
  input logic              override_moving
);
  import hams_pkg::*;

  // a stalled result word stays offered
  `HAMS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // an encoder reset only comes with the arm stopped in idle
  `HAMS_ASSERT_NOW(a_reset_idle, out_valid && encoder_reset,
                   motor_drive == $signed(DRV_STOP) && sequence_step == ST_IDLE)

  // pull override still moving means idle, retracting, and no encoder reset
  `HAMS_ASSERT_NOW(a_pull_moving, out_valid && override_moving,
                   motor_drive == $signed(DRV_BACK) && sequence_step == ST_IDLE
                   && !encoder_reset)

  // the drive never shows the unused code
  `HAMS_ASSERT_NOW(a_drive_code, out_valid, motor_drive != 2'sb10)

endmodule

bind hook_arm_motion_sequencer_core hams_checker u_hams_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .motor_drive     (out_if.motor_drive),
  .encoder_reset   (out_if.encoder_reset),
  .sequence_step   (out_if.sequence_step),
  .override_moving (out_if.override_moving)
);
